/* hw/rtl/mrl_pkg.sv */
// ----------------------------------------------------------------------------
// mrl_pkg
// Shared types and constants of the message rate limiter.
// ----------------------------------------------------------------------------
package mrl_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int STAMP_W    = 64;
    localparam int TICKS_W    = 32;
    localparam int SKIP_W     = 32;
    localparam int SCALE_SHIFT = 10;
    localparam int SCALED_W   = STAMP_W - SCALE_SHIFT;
    localparam int VERDICT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [TICKS_W-1:0] WINDOW_RESET = TICKS_W'(1000000);
    localparam logic [TICKS_W-1:0] SLEEP_RESET  = TICKS_W'(1000000);
    localparam logic [SKIP_W-1:0]  SKIP_MAX     = '1;

    typedef enum logic [VERDICT_W-1:0] {
        V_PASS     = 3'd0,
        V_RESUME   = 3'd1,
        V_SUPPRESS = 3'd2,
        V_SKIP     = 3'd3,
        V_DISABLED = 3'd4
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW  = 2'd0,
        CFG_SLEEP   = 2'd1,
        CFG_DISABLE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_verdict              verdict;
        logic [SKIP_W-1:0]     skipped_reported;
        logic                  delta_negative;
        logic [SCALED_W-1:0]   delta_value;
    } t_result;

endpackage

/* hw/rtl/mrl_ifs.sv */
// ----------------------------------------------------------------------------
// mrl_ifs
// Valid/ready channels of the message rate limiter: requests, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface mrl_req_if
    import mrl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] stamp;

    modport source (output valid, output stamp, input ready);
    modport sink   (input valid, input stamp, output ready);
endinterface

interface mrl_res_if
    import mrl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [SKIP_W-1:0]    skipped_reported;
    logic                 delta_negative;
    logic [SCALED_W-1:0]  delta_value;

    modport source (output valid, output verdict, output skipped_reported,
                    output delta_negative, output delta_value, input ready);
    modport sink   (input valid, input verdict, input skipped_reported,
                    input delta_negative, input delta_value, output ready);
endinterface

interface mrl_cfg_if
    import mrl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/message_rate_limiter.sv */
// ----------------------------------------------------------------------------
// message_rate_limiter
// Sliding-window rate limiter for time-stamped message requests.
// Throughput: one request per cycle while the skid stage is empty; the ring
// memory is read and written once per cycle and the oldest entry is prefetched
// with write forwarding.
// Reset clears pointers, counters and the output stage and restores the reset
// configuration; the ring memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module message_rate_limiter
    import mrl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mrl_req_if.sink   i_req,
    mrl_res_if.source o_res,
    mrl_cfg_if.sink   i_cfg
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        return (p == LAST_POS) ? '0 : p + PTR_W'(1);
    endfunction

    logic [STAMP_W-1:0]  r_ring_mem [DEPTH];
    logic [STAMP_W-1:0]  r_oldest;

    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SKIP_W-1:0]   r_skip, n_skip;
    logic [SCALED_W-1:0] r_last_scaled, n_last_scaled;
    logic [STAMP_W-1:0]  r_newest, n_newest;

    logic [TICKS_W-1:0]  r_window;
    logic [TICKS_W-1:0]  r_sleep;
    logic                r_disable;

    t_result             r_out, r_skid, n_result;
    logic                r_out_valid, r_skid_valid;

    logic                accept;
    logic                take;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [STAMP_W-1:0]  since_newest;
    logic [STAMP_W-1:0]  since_oldest;
    logic [SCALED_W-1:0] scaled;
    logic                resume;
    logic [PTR_W-1:0]    base_head;
    logic [PTR_W-1:0]    base_tail;
    logic [CNT_W-1:0]    base_count;
    logic                full;

    assign i_req.ready = !r_skid_valid;
    assign accept      = i_req.valid && !r_skid_valid;
    assign take        = r_out_valid && o_res.ready;
    assign i_cfg.ready = 1'b1;

    assign since_newest = i_req.stamp - r_newest;
    assign since_oldest = i_req.stamp - r_oldest;
    assign scaled       = i_req.stamp[STAMP_W-1:SCALE_SHIFT];

    always_comb begin
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_skip        = r_skip;
        n_last_scaled = r_last_scaled;
        n_newest      = r_newest;
        wr_en         = 1'b0;
        n_result      = '0;
        resume        = (r_skip != '0);
        base_head     = resume ? '0 : r_head;
        base_tail     = resume ? '0 : r_tail;
        base_count    = resume ? '0 : r_count;
        full          = (base_count == FULL_CNT);
        wr_addr       = base_tail;

        if (r_disable) begin
            n_result.verdict = V_DISABLED;
        end else if (resume && (since_newest <= {32'd0, r_sleep})) begin
            n_result.verdict = V_SKIP;
            if (accept && r_skip != SKIP_MAX) begin
                n_skip = r_skip + SKIP_W'(1);
            end
        end else if (full && (since_oldest <= {32'd0, r_window})) begin
            n_result.verdict = V_SUPPRESS;
            if (accept) begin
                n_skip = SKIP_W'(1);
            end
        end else begin
            n_result.verdict          = resume ? V_RESUME : V_PASS;
            n_result.skipped_reported = resume ? r_skip : '0;
            if (scaled > r_last_scaled) begin
                n_result.delta_negative = 1'b0;
                n_result.delta_value    = scaled - r_last_scaled;
            end else begin
                n_result.delta_negative = 1'b1;
                n_result.delta_value    = r_last_scaled - scaled;
            end
            if (accept) begin
                wr_en         = 1'b1;
                n_skip        = '0;
                n_tail        = next_pos(base_tail);
                n_head        = full ? next_pos(base_head) : base_head;
                n_count       = full ? base_count : base_count + CNT_W'(1);
                n_last_scaled = scaled;
                n_newest      = i_req.stamp;
            end
        end
    end

    // The oldest entry is read ahead into a register from the next head position.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring_mem[wr_addr] <= i_req.stamp;
        end
        if (wr_en && wr_addr == n_head) begin
            r_oldest <= i_req.stamp;
        end else begin
            r_oldest <= r_ring_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_skip        <= '0;
            r_last_scaled <= '0;
            r_newest      <= '0;
        end else begin
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_skip        <= n_skip;
            r_last_scaled <= n_last_scaled;
            r_newest      <= n_newest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RESET;
            r_sleep   <= SLEEP_RESET;
            r_disable <= 1'b0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_WINDOW:  r_window  <= i_cfg.data[TICKS_W-1:0];
                CFG_SLEEP:   r_sleep   <= i_cfg.data[TICKS_W-1:0];
                CFG_DISABLE: r_disable <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Output register with a skid stage, so a request is taken while a
    // result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.verdict          = r_out.verdict;
    assign o_res.skipped_reported = r_out.skipped_reported;
    assign o_res.delta_negative   = r_out.delta_negative;
    assign o_res.delta_value      = r_out.delta_value;

endmodule

/* hw/rtl/mrl_checker.sv */
// ----------------------------------------------------------------------------
// mrl_checker
// Port-level checks of the message rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module mrl_checker
    import mrl_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_res_valid,
    input logic                 i_res_ready,
    input logic [VERDICT_W-1:0] i_verdict,
    input logic [SKIP_W-1:0]    i_skipped,
    input logic                 i_neg,
    input logic [SCALED_W-1:0]  i_delta
);

    // A skip count is reported only on a resume, and then it is never zero.
    a_report_only_on_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_verdict != V_RESUME |-> i_skipped == '0)
        else $error("skip count reported without a resume");

    a_resume_reports_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_verdict == V_RESUME |-> i_skipped != '0)
        else $error("resume reported an empty skip count");

    // Only passing requests carry a time difference.
    a_delta_only_on_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_verdict != V_PASS && i_verdict != V_RESUME
        |-> !i_neg && i_delta == '0)
        else $error("time difference on a request that did not pass");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_verdict)
        && $stable(i_skipped) && $stable(i_delta))
        else $error("stalled result changed");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind message_rate_limiter mrl_checker u_mrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_verdict   (o_res.verdict),
    .i_skipped   (o_res.skipped_reported),
    .i_neg       (o_res.delta_negative),
    .i_delta     (o_res.delta_value)
);

/* sim/tb_message_rate_limiter.sv */
// ----------------------------------------------------------------------------
// tb_message_rate_limiter
// Self-checking testbench for the message rate limiter. Stamped requests are
// driven on the request channel and every result is compared field by field
// against an in-bench predictor of the sliding-window limiter. A short
// directed sequence is followed by bursts of closely spaced stamps, quiet
// jumps and random noise under several window, sleep and disable settings,
// with random idling on both channels and one long result back-pressure.
// ----------------------------------------------------------------------------
module tb_message_rate_limiter;
    import mrl_pkg::*;

    localparam int          RING_DEPTH  = DEPTH_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    mrl_req_if req_bus ();
    mrl_res_if res_bus ();
    mrl_cfg_if cfg_bus ();

    message_rate_limiter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Predictor state and configuration.
    logic [STAMP_W-1:0]  ring_times [RING_DEPTH];
    int unsigned         ring_rd     = 0;
    int unsigned         ring_wr     = 0;
    int unsigned         ring_fill   = 0;
    logic [SKIP_W-1:0]   skips       = '0;
    logic [SCALED_W-1:0] last_scaled = '0;
    logic [TICKS_W-1:0]  win_cfg     = WINDOW_RESET;
    logic [TICKS_W-1:0]  sleep_cfg   = SLEEP_RESET;
    logic                disable_cfg = 1'b0;

    logic [STAMP_W-1:0] stamp_backlog [$];
    t_result            expected_verdicts [$];
    logic [STAMP_W-1:0] clock_now      = '0;
    int unsigned        n_queued       = 0;
    int unsigned        n_accepted     = 0;
    int unsigned        fail_count     = 0;
    int unsigned        cycle_count    = 0;
    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;
    logic               req_fire       = 1'b0;
    logic               hold_active    = 1'b0;
    event               hold_go;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_result predict_verdict(input logic [STAMP_W-1:0] s);
        t_result             r;
        logic [SKIP_W-1:0]   reported;
        logic [SCALED_W-1:0] scaled;
        int unsigned         newest_at;
        bit                  resumed;
        r = '0;
        reported = '0;
        resumed = 1'b0;
        if (disable_cfg) begin
            r.verdict = V_DISABLED;
            return r;
        end
        if (skips != '0) begin
            newest_at = (ring_wr == 0) ? RING_DEPTH - 1 : ring_wr - 1;
            if (s - ring_times[newest_at] <= STAMP_W'(sleep_cfg)) begin
                if (skips != SKIP_MAX) skips++;
                r.verdict = V_SKIP;
                return r;
            end
            ring_rd = 0;
            ring_wr = 0;
            ring_fill = 0;
            reported = skips;
            skips = '0;
            resumed = 1'b1;
        end
        if (ring_fill == RING_DEPTH) begin
            if (s - ring_times[ring_rd] <= STAMP_W'(win_cfg)) begin
                skips = SKIP_W'(1);
                r.verdict = V_SUPPRESS;
                return r;
            end
            ring_rd = (ring_rd + 1) % RING_DEPTH;
            ring_fill--;
        end
        ring_times[ring_wr] = s;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        ring_fill++;
        scaled = s[STAMP_W-1:SCALE_SHIFT];
        r.delta_negative = !(scaled > last_scaled);
        r.delta_value = r.delta_negative ? last_scaled - scaled : scaled - last_scaled;
        last_scaled = scaled;
        r.verdict = resumed ? V_RESUME : V_PASS;
        r.skipped_reported = reported;
        return r;
    endfunction

    function void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_WINDOW:  win_cfg = value;
            CFG_SLEEP:   sleep_cfg = value;
            CFG_DISABLE: disable_cfg = value[0];
            default: ;
        endcase
    endfunction

    function void check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, label, want, got);
            fail_count++;
        end
    endfunction

    function void add_stamp(input logic [STAMP_W-1:0] s);
        stamp_backlog.push_back(s);
        n_queued++;
    endfunction

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        apply_setting(idx, value);
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Bursts of close stamps can fill the ring and trigger suppression; the jump
    // after most bursts ends suppression or lands exactly on the sleep edge.
    task automatic queue_traffic(input int unsigned n_items);
        int unsigned        target;
        int unsigned        run_len;
        int unsigned        step_cap;
        int unsigned        pick;
        logic [STAMP_W-1:0] noise;
        target = n_queued + n_items;
        while (n_queued < target) begin
            if ($urandom_range(99) < 80) begin
                run_len = $urandom_range(40, 12);
                step_cap = win_cfg / (($urandom_range(3) == 0) ? 8 : 24);
                repeat (run_len) begin
                    if ($urandom_range(3) != 0) clock_now += 64'($urandom_range(step_cap));
                    add_stamp(clock_now);
                end
                pick = $urandom_range(99);
                if (pick < 70) begin
                    clock_now += 64'(sleep_cfg) + 64'($urandom_range(8, 1));
                    add_stamp(clock_now);
                end else if (pick < 85) begin
                    clock_now += 64'(sleep_cfg);
                    add_stamp(clock_now);
                end
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    noise = {$urandom, $urandom};
                    if ($urandom_range(1) == 0) clock_now = noise;
                    add_stamp(noise);
                end
            end
        end
    endtask

    task automatic run_phase(input logic [TICKS_W-1:0] window, input logic [TICKS_W-1:0] quiet,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input bit hold, input int unsigned n_items);
        write_setting(CFG_WINDOW, window);
        write_setting(CFG_SLEEP, quiet);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (hold) -> hold_go;
        queue_traffic(n_items);
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_fire) begin
            if (stamp_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_bus.valid <= 1'b1;
                req_bus.stamp <= stamp_backlog.pop_front();
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always begin
        @(hold_go);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            req_fire <= req_bus.valid && req_bus.ready;
            if (req_bus.valid && req_bus.ready) begin
                expected_verdicts.push_back(predict_verdict(req_bus.stamp));
                n_accepted++;
            end
            if (res_bus.valid && res_bus.ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got verdict %0d",
                             $time, res_bus.verdict);
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("verdict", 64'(want.verdict), 64'(res_bus.verdict));
                    check_field("skipped_reported", 64'(want.skipped_reported),
                                64'(res_bus.skipped_reported));
                    check_field("delta_negative", 64'(want.delta_negative),
                                64'(res_bus.delta_negative));
                    check_field("delta_value", 64'(want.delta_value),
                                64'(res_bus.delta_value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.stamp = '0;
        res_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_WINDOW;
        cfg_bus.data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: fill the ring, hit the window and sleep edges exactly.
        add_stamp('0);
        add_stamp('1);
        add_stamp(64'd1024);
        for (int k = 0; k < 13; k++) add_stamp(64'd2000 + 64'(k * 10));
        add_stamp(64'(WINDOW_RESET));
        add_stamp(64'd2120 + 64'(SLEEP_RESET));
        add_stamp(64'd2121 + 64'(SLEEP_RESET));
        wait_drained();
        write_setting(CFG_DISABLE, 1);
        add_stamp('0);
        add_stamp('1);
        wait_drained();
        write_setting(CFG_UNUSED, '0);
        add_stamp(64'h8000_0000_0000_0000);
        wait_drained();
        write_setting(CFG_DISABLE, 0);

        run_phase(5000, 20000, 0, 0, 1'b0, 350);
        run_phase('0, '0, 82, 0, 1'b0, 300);
        run_phase('1, '1, 0, 82, 1'b0, 300);
        run_phase($urandom_range(200, 1), $urandom_range(500, 1), 28, 28, 1'b0, 350);
        run_phase(3000, 100000, 0, 0, 1'b1, 300);
        write_setting(CFG_DISABLE, 1);
        run_phase($urandom, $urandom, 28, 28, 1'b0, 60);
        write_setting(CFG_DISABLE, 0);
        run_phase($urandom, $urandom, 28, 28, 1'b0, 200);

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
